>>> sv/teq_pkg.sv
// Shared types and constants for the timed event queue.
`default_nettype none

package teq_pkg;

    localparam int TIME_W       = 32;
    localparam int TGT_W        = 8;
    localparam int DEFAULT_DEPTH = 64;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } teq_status_t;

    // Broadcast to every cell each cycle
    typedef struct packed {
        logic              ins;   // accepted insert that fits
        logic              pop;   // accepted pop on a non-empty queue
        logic [TIME_W-1:0] key;
        logic [TGT_W-1:0]  tgt;
    } teq_ctrl_t;

endpackage

`default_nettype wire

>>> sv/timed_event_queue_unit.sv
// Timed event queue: a sorted shift chain of cells with a registered result.
// Result is presented in the cycle after the input beat is taken. One insert
// or pop per cycle while m_tready is high; each cell does one 32-bit compare
// against the broadcast key in parallel, so the chain depth does not set rate.
// Reset clears the occupancy count and the result valid; cell contents are
// left as they are and only slots below the occupancy count are ever used.
`default_nettype none

module timed_event_queue_unit
    import teq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // event_time[31:0], event_target[39:32]
    input  wire logic [0:0]  s_tuser,   // cmd[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_time[31:0], out_target[39:32]
    output logic [1:0]       m_tuser    // status[1:0]
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             out_valid_reg, out_valid_next;
    logic [39:0]      out_data_reg, out_data_next;
    teq_status_t      out_status_reg, out_status_next;

    logic             accept;
    logic             is_pop;
    logic             full;
    logic             empty;
    teq_ctrl_t        ctrl;

    logic [TIME_W-1:0] cell_time [QUEUE_DEPTH];
    logic [TGT_W-1:0]  cell_tgt  [QUEUE_DEPTH];
    logic              cell_ge   [QUEUE_DEPTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_pop   = (s_tuser[0] == CMD_POP);
    assign full     = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign empty    = (occ_reg == '0);

    always_comb
    begin
        ctrl.ins = accept && !is_pop && !full;
        ctrl.pop = accept && is_pop && !empty;
        ctrl.key = s_tdata[TIME_W-1:0];
        ctrl.tgt = s_tdata[TIME_W +: TGT_W];
    end

    generate
        for (genvar i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic              lge;
            logic [TIME_W-1:0] ltime, rtime;
            logic [TGT_W-1:0]  ltgt, rtgt;

            if (i == 0)
            begin : g_head
                assign lge   = 1'b0;
                assign ltime = '0;
                assign ltgt  = '0;
            end
            else
            begin : g_mid
                assign lge   = cell_ge[i-1];
                assign ltime = cell_time[i-1];
                assign ltgt  = cell_tgt[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign rtime = cell_time[i];
                assign rtgt  = cell_tgt[i];
            end
            else
            begin : g_body
                assign rtime = cell_time[i+1];
                assign rtgt  = cell_tgt[i+1];
            end

            teq_cell #(
                .QUEUE_DEPTH(QUEUE_DEPTH),
                .INDEX      (i)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occ       (occ_reg),
                .left_ge   (lge),
                .left_time (ltime),
                .left_tgt  (ltgt),
                .right_time(rtime),
                .right_tgt (rtgt),
                .ge        (cell_ge[i]),
                .time_q    (cell_time[i]),
                .tgt_q     (cell_tgt[i])
            );
        end
    endgenerate

    // Occupancy next state
    always_comb
    begin
        occ_next = occ_reg;
        if (ctrl.ins)
            occ_next = occ_reg + OCC_W'(1);
        else if (ctrl.pop)
            occ_next = occ_reg - OCC_W'(1);
    end

    // Result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        if (accept)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = '0;
            out_status_next = ST_DONE;
            if (is_pop)
            begin
                if (empty)
                    out_status_next = ST_EMPTY;
                else
                    out_data_next = {cell_tgt[0], cell_time[0]};
            end
            else if (full)
            begin
                out_status_next = ST_FULL;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy above depth");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> occ_reg == $past(occ_reg) + OCC_W'(1))
        else $error("insert did not grow occupancy");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_pop && full) |=> (m_tuser == ST_FULL) && (occ_reg == $past(occ_reg)))
        else $error("full insert not flagged or changed state");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata == '0))
        else $error("empty pop returned data");
`endif

endmodule

`default_nettype wire

>>> sv/teq_cell.sv
// One slot of the sorted chain: holds an event and shifts with its neighbors.
`default_nettype none

module teq_cell
    import teq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH,
    parameter int INDEX       = 0
) (
    input  wire logic                                 clk,
    input  wire teq_ctrl_t                            ctrl,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]     occ,
    input  wire logic                                 left_ge,
    input  wire logic [TIME_W-1:0]                    left_time,
    input  wire logic [TGT_W-1:0]                     left_tgt,
    input  wire logic [TIME_W-1:0]                    right_time,
    input  wire logic [TGT_W-1:0]                     right_tgt,
    output logic                                      ge,
    output logic [TIME_W-1:0]                         time_q,
    output logic [TGT_W-1:0]                          tgt_q
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic [TIME_W-1:0] time_reg, time_next;
    logic [TGT_W-1:0]  tgt_reg, tgt_next;
    logic              valid;

    assign valid  = occ > OCC_W'(INDEX);
    // New event lands at the first slot not strictly earlier than it
    assign ge     = !valid || (time_reg >= ctrl.key);
    assign time_q = time_reg;
    assign tgt_q  = tgt_reg;

    always_comb
    begin
        time_next = time_reg;
        tgt_next  = tgt_reg;
        if (ctrl.ins && ge)
        begin
            if (left_ge)
            begin
                time_next = left_time;
                tgt_next  = left_tgt;
            end
            else
            begin
                time_next = ctrl.key;
                tgt_next  = ctrl.tgt;
            end
        end
        else if (ctrl.pop)
        begin
            time_next = right_time;
            tgt_next  = right_tgt;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        tgt_reg  <= tgt_next;
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_timed_event_queue_unit.sv
// Self-checking testbench for timed_event_queue_unit: sorted-list predictor and result scoreboard.
module tb_timed_event_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import teq_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;

    typedef struct {
        logic [TIME_W-1:0] t;
        logic [TGT_W-1:0]  tgt;
    } sched_event_t;

    typedef struct {
        logic [TIME_W-1:0] t;
        logic [TGT_W-1:0]  tgt;
        teq_status_t       status;
    } pop_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // event_time[31:0], event_target[39:32]
    logic [0:0]  s_tuser;   // cmd[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // out_time[31:0], out_target[39:32]
    logic [1:0]  m_tuser;   // status[1:0]

    sched_event_t sched_q[$];     // predicted queue contents, head first
    pop_result_t  result_q[$];    // results owed by the block, oldest first

    int err_count = 0;
    int checked = 0;
    int n_ins = 0;
    int n_pop = 0;
    int n_full = 0;
    int n_empty = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_left = 0;

    timed_event_queue_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Apply one accepted beat to the predicted queue and return the result it owes.
    function automatic pop_result_t apply_event(input logic cmd, input logic [TIME_W-1:0] t,
                                                input logic [TGT_W-1:0] tgt);
        pop_result_t  r;
        sched_event_t ev;
        int           pos;
        r.t = '0;
        r.tgt = '0;
        r.status = ST_DONE;
        if (cmd == CMD_INSERT)
        begin
            if (sched_q.size() >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                // new event lands ahead of any equal times
                pos = 0;
                while (pos < sched_q.size() && sched_q[pos].t < t)
                    pos++;
                ev.t = t;
                ev.tgt = tgt;
                sched_q.insert(pos, ev);
            end
        end
        else if (sched_q.size() == 0)
            r.status = ST_EMPTY;
        else
        begin
            ev = sched_q.pop_front();
            r.t = ev.t;
            r.tgt = ev.tgt;
        end
        return r;
    endfunction

    // Input beats first, so a result in the same cycle would still find its expectation.
    always @(posedge clk)
    begin : scoreboard
        pop_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                want = apply_event(s_tuser[0], s_tdata[31:0], s_tdata[39:32]);
                if (s_tuser[0] == CMD_INSERT)
                    n_ins++;
                else
                    n_pop++;
                if (want.status == ST_FULL)
                    n_full++;
                if (want.status == ST_EMPTY)
                    n_empty++;
                result_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = result_q.pop_front();
                    checked++;
                    if (m_tdata[31:0] !== want.t)
                        report_mismatch($sformatf("out_time got %h want %h",
                                                  m_tdata[31:0], want.t));
                    if (m_tdata[39:32] !== want.tgt)
                        report_mismatch($sformatf("out_target got %h want %h",
                                                  m_tdata[39:32], want.tgt));
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status got %0d want %s",
                                                  m_tuser, want.status.name()));
                end
            end
        end
    end

    // Sink side: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_event(input logic cmd, input logic [TIME_W-1:0] t,
                              input logic [TGT_W-1:0] tgt);
        int gap;
        gap = 0;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {tgt, t};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop sending and wait for every owed result, bounded.
    task automatic wait_drained();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (result_q.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    // Half tie-prone small times and times near the top, half full-range values.
    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(3))
            0: return TIME_W'($urandom_range(7));
            1: return 32'hFFFF_FFF8 | TIME_W'($urandom_range(7));
            default: return TIME_W'($urandom());
        endcase
    endfunction

    task automatic test_directed();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_event(CMD_POP, '1, '1);                    // pop on empty
        send_event(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF);
        send_event(CMD_INSERT, 32'd0, 8'h00);
        send_event(CMD_INSERT, 32'd100, 8'hA5);
        send_event(CMD_INSERT, 32'd100, 8'h5A);         // equal time, goes first
        send_event(CMD_INSERT, 32'd0, 8'h11);           // equal to the head
        send_event(CMD_INSERT, 32'hFFFF_FFFF, 8'h22);
        send_event(CMD_INSERT, 32'hAAAA_AAAA, 8'h55);
        send_event(CMD_INSERT, 32'h5555_5555, 8'hAA);
        repeat (9) send_event(CMD_POP, '0, '0);         // last one finds it empty
        wait_drained();
    endtask

    task automatic test_fill_full();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        repeat (DEPTH) send_event(CMD_INSERT, pick_time(), TGT_W'($urandom_range(255)));
        // source pauses until every result is back before overfilling
        wait_drained();
        repeat (3) send_event(CMD_INSERT, pick_time(), TGT_W'($urandom_range(255)));
        send_event(CMD_POP, '0, '0);
        send_event(CMD_INSERT, 32'd0, 8'h7E);
        send_event(CMD_INSERT, 32'd1, 8'h81);           // full again
        repeat (DEPTH + 1) send_event(CMD_POP, TIME_W'($urandom()), TGT_W'($urandom_range(255)));
        wait_drained();
    endtask

    task automatic test_backpressure();
        int k;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left <= 200;
        for (k = 0; k < 40; k++)
            send_event(($urandom_range(99) < 30) ? CMD_POP : CMD_INSERT, pick_time(),
                       TGT_W'($urandom_range(255)));
        wait_drained();
    endtask

    task automatic test_random(input int src_pct, input int sink_pct, input int n_items);
        int sent;
        int burst;
        int pop_pct;
        int k;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        while (sent < n_items)
        begin
            // bursts lean toward filling, draining or neither
            burst = $urandom_range(80, 20);
            case ($urandom_range(2))
                0: pop_pct = 15;
                1: pop_pct = 85;
                default: pop_pct = 50;
            endcase
            for (k = 0; k < burst && sent < n_items; k++)
            begin
                send_event(($urandom_range(99) < pop_pct) ? CMD_POP : CMD_INSERT, pick_time(),
                           TGT_W'($urandom_range(255)));
                sent++;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_full();
        test_backpressure();
        test_random(0, 0, 300);
        test_random(82, 0, 300);
        test_random(0, 82, 300);
        test_random(38, 38, 300);

        wait_drained();
        repeat (10) @(posedge clk);
        if (result_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", result_q.size()));

        $display("Run covered %0d inserts (%0d dropped on full) and %0d pops (%0d on empty);",
                 n_ins, n_full, n_pop, n_empty);
        $display("%0d result beats checked across free-running, sparse, stalled %s",
                 checked, "and held-off traffic.");
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout");
        $display("FAILURE");
        $finish;
    end

endmodule
